// ===== src/fmbq_pkg.sv =====
// Shared types and codes for the front/middle/back queue.
package fmbq_pkg;

  localparam int IN_BITS  = 32;
  localparam int OUT_BITS = 32;
  localparam int OCC_BITS = 10;

  // Input mode codes
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_MID   = 3'd1;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [2:0] MODE_POP_MID    = 3'd4;
  localparam logic [2:0] MODE_POP_BACK   = 3'd5;

  typedef enum logic [2:0] {
    OP_NOP        = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_MID   = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_MID    = 3'd5,
    OP_POP_BACK   = 3'd6
  } op_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] pop_value;
    logic                       was_empty;
    logic                       push_dropped;
    logic [OCC_BITS-1:0]        occupancy;
  } res_t;

  typedef struct packed {
    logic balanced;  // front count equals back count or exceeds it by one
    logic over_cap;  // total above capacity
  } stat_t;

endpackage

// ===== src/fmbq_fifo.sv =====
// Small register FIFO used for the command and result queues.
module fmbq_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNTW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== src/fmbq_front.sv =====
// Front end: takes input beats, decodes the mode and queues commands.
module fmbq_front import fmbq_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [2:0]            in_mode,
  input  logic [IN_BITS-1:0]    in_push_value,
  output logic                  cmd_empty,
  output op_t                   cmd_op,
  output logic [VALUE_BITS-1:0] cmd_value,
  input  logic                  cmd_pop
);

  localparam int CMD_BITS = $bits(op_t) + VALUE_BITS;

  op_t                  op_dec;
  logic [63:0]          value_ext;
  logic [CMD_BITS-1:0]  cmd_in, cmd_out;

  always_comb begin
    case (in_mode)
      MODE_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      MODE_PUSH_MID:   op_dec = OP_PUSH_MID;
      MODE_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      MODE_POP_FRONT:  op_dec = OP_POP_FRONT;
      MODE_POP_MID:    op_dec = OP_POP_MID;
      MODE_POP_BACK:   op_dec = OP_POP_BACK;
      default:         op_dec = OP_NOP;
    endcase
  end

  // keep only the stored value width
  assign value_ext = {32'b0, in_push_value};
  assign cmd_in    = {op_dec, value_ext[VALUE_BITS-1:0]};

  fmbq_fifo #(
    .WIDTH (CMD_BITS),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .dout  (cmd_out)
  );

  assign cmd_op    = op_t'(cmd_out[CMD_BITS-1:VALUE_BITS]);
  assign cmd_value = cmd_out[VALUE_BITS-1:0];

endmodule

// ===== src/fmbq_back.sv =====
// Back end: two ring-buffer halves, one operation at a time (an access state, then a move state).
module fmbq_back import fmbq_pkg::*; #(
  parameter int HALF_DEPTH = 512,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  input  op_t                   cmd_op,
  input  logic [VALUE_BITS-1:0] cmd_value,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output res_t                  res_data,
  output stat_t                 stat
);

  localparam int AW = $clog2(HALF_DEPTH);
  localparam int CW = $clog2(HALF_DEPTH + 1);
  localparam int TW = $clog2(2 * HALF_DEPTH);
  localparam logic [TW-1:0] CAPACITY = TW'(2 * HALF_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_MOVE = 2'b10
  } state_t;

  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_FRONT = 2'd1,
    SRC_BACK  = 2'd2
  } src_t;

  function automatic logic [AW-1:0] ring(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(off);
    if (s >= (CW+1)'(HALF_DEPTH)) begin
      s = s - (CW+1)'(HALF_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] sext(input logic [VALUE_BITS-1:0] v);
    logic signed [VALUE_BITS-1:0] sv;
    logic signed [63:0]           w;
    sv = v;
    w  = 64'(sv);
    return w[OUT_BITS-1:0];
  endfunction

  logic [VALUE_BITS-1:0] f_mem_r [HALF_DEPTH];
  logic [VALUE_BITS-1:0] b_mem_r [HALF_DEPTH];
  logic [VALUE_BITS-1:0] f_rd_r, b_rd_r;

  state_t          state_r;
  logic [AW-1:0]   fh_r, bh_r, fh_nxt, bh_nxt;
  logic [CW-1:0]   fc_r, bc_r, fc_nxt, bc_nxt;
  logic            mv_en_r, mv_to_f_r, mv_en_nxt, mv_to_f_nxt;
  logic [AW-1:0]   mv_addr_r, mv_addr_nxt;
  src_t            sel_r, sel_nxt;
  logic            empty_r, empty_nxt, drop_r, drop_nxt;
  logic [OCC_BITS-1:0] occ_r;

  logic            go, full, fc_eq, fc_gt;
  logic [TW-1:0]   tot, tot_nxt;
  logic [TW+OCC_BITS-1:0] tot_ext;
  logic [AW-1:0]   fh_inc, fh_dec, bh_inc, bh_dec, f_last, f_tail, b_tail, b_last;
  logic            f_we1, b_we1, f_we, b_we;
  logic [AW-1:0]   f_wa1, b_wa1, f_wa, b_wa, f_ra, b_ra;
  logic [VALUE_BITS-1:0] f_wd, b_wd;

  assign go    = (state_r == S_IDLE) && !cmd_empty && !res_full;
  assign tot   = TW'(fc_r) + TW'(bc_r);
  assign full  = (tot == CAPACITY);
  assign fc_eq = (fc_r == bc_r);
  assign fc_gt = (fc_r == bc_r + CW'(1));

  assign fh_inc = ring(fh_r, CW'(1));
  assign fh_dec = ring(fh_r, CW'(HALF_DEPTH - 1));
  assign bh_inc = ring(bh_r, CW'(1));
  assign bh_dec = ring(bh_r, CW'(HALF_DEPTH - 1));
  assign f_last = ring(fh_r, fc_r - CW'(1));
  assign f_tail = ring(fh_r, fc_r);
  assign b_last = ring(bh_r, bc_r - CW'(1));
  assign b_tail = ring(bh_r, bc_r);

  // accepting idle state: decision, at most one write with the new value, reads for the move and the popped value
  always_comb begin
    fh_nxt      = fh_r;
    bh_nxt      = bh_r;
    fc_nxt      = fc_r;
    bc_nxt      = bc_r;
    f_we1       = 1'b0;
    b_we1       = 1'b0;
    f_wa1       = f_tail;
    b_wa1       = b_tail;
    f_ra        = f_last;
    b_ra        = bh_r;
    mv_en_nxt   = 1'b0;
    mv_to_f_nxt = 1'b0;
    mv_addr_nxt = bh_dec;
    sel_nxt     = SRC_NONE;
    empty_nxt   = 1'b0;
    drop_nxt    = 1'b0;
    case (cmd_op)
      OP_PUSH_FRONT: begin
        if (full) begin
          drop_nxt = 1'b1;
        end else begin
          f_we1  = 1'b1;
          f_wa1  = fh_dec;
          fh_nxt = fh_dec;
          if (fc_gt) begin
            mv_en_nxt   = 1'b1;
            mv_addr_nxt = bh_dec;
            bh_nxt      = bh_dec;
            bc_nxt      = bc_r + CW'(1);
          end else begin
            fc_nxt = fc_r + CW'(1);
          end
        end
      end
      OP_PUSH_MID: begin
        if (full) begin
          drop_nxt = 1'b1;
        end else if (fc_gt) begin
          // old last element leaves through the read port, new value takes its slot
          f_we1       = 1'b1;
          f_wa1       = f_last;
          mv_en_nxt   = 1'b1;
          mv_addr_nxt = bh_dec;
          bh_nxt      = bh_dec;
          bc_nxt      = bc_r + CW'(1);
        end else begin
          f_we1  = 1'b1;
          f_wa1  = f_tail;
          fc_nxt = fc_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          drop_nxt = 1'b1;
        end else if (fc_eq && bc_r == '0) begin
          f_we1  = 1'b1;
          f_wa1  = f_tail;
          fc_nxt = fc_r + CW'(1);
        end else if (fc_eq) begin
          b_we1       = 1'b1;
          b_wa1       = b_tail;
          mv_en_nxt   = 1'b1;
          mv_to_f_nxt = 1'b1;
          mv_addr_nxt = f_tail;
          bh_nxt      = bh_inc;
          fc_nxt      = fc_r + CW'(1);
        end else begin
          b_we1  = 1'b1;
          b_wa1  = b_tail;
          bc_nxt = bc_r + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (fc_r == '0) begin
          empty_nxt = 1'b1;
        end else begin
          f_ra    = fh_r;
          sel_nxt = SRC_FRONT;
          fh_nxt  = fh_inc;
          if (fc_eq) begin
            mv_en_nxt   = 1'b1;
            mv_to_f_nxt = 1'b1;
            mv_addr_nxt = f_tail;
            bh_nxt      = bh_inc;
            bc_nxt      = bc_r - CW'(1);
          end else begin
            fc_nxt = fc_r - CW'(1);
          end
        end
      end
      OP_POP_MID: begin
        if (fc_r == '0) begin
          empty_nxt = 1'b1;
        end else begin
          sel_nxt = SRC_FRONT;
          if (fc_eq) begin
            mv_en_nxt   = 1'b1;
            mv_to_f_nxt = 1'b1;
            mv_addr_nxt = f_last;
            bh_nxt      = bh_inc;
            bc_nxt      = bc_r - CW'(1);
          end else begin
            fc_nxt = fc_r - CW'(1);
          end
        end
      end
      OP_POP_BACK: begin
        if (fc_r == '0) begin
          empty_nxt = 1'b1;
        end else if (bc_r == '0) begin
          sel_nxt = SRC_FRONT;
          fc_nxt  = fc_r - CW'(1);
        end else begin
          b_ra    = b_last;
          sel_nxt = SRC_BACK;
          if (fc_gt) begin
            mv_en_nxt   = 1'b1;
            mv_addr_nxt = bh_dec;
            bh_nxt      = bh_dec;
            fc_nxt      = fc_r - CW'(1);
          end else begin
            bc_nxt = bc_r - CW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign tot_nxt = TW'(fc_nxt) + TW'(bc_nxt);
  assign tot_ext = (TW+OCC_BITS)'(tot_nxt);

  // memory ports: the accepting idle state writes the new value, the move state the moved one
  assign f_we = (go && f_we1) || (state_r == S_MOVE && mv_en_r && mv_to_f_r);
  assign b_we = (go && b_we1) || (state_r == S_MOVE && mv_en_r && !mv_to_f_r);
  assign f_wa = (state_r == S_MOVE) ? mv_addr_r : f_wa1;
  assign b_wa = (state_r == S_MOVE) ? mv_addr_r : b_wa1;
  assign f_wd = (state_r == S_MOVE) ? b_rd_r : cmd_value;
  assign b_wd = (state_r == S_MOVE) ? f_rd_r : cmd_value;

  always_ff @(posedge clk) begin
    if (f_we) begin
      f_mem_r[f_wa] <= f_wd;
    end
    f_rd_r <= f_mem_r[f_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem_r[b_wa] <= b_wd;
    end
    b_rd_r <= b_mem_r[b_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fh_r    <= '0;
      bh_r    <= '0;
      fc_r    <= '0;
      bc_r    <= '0;
      mv_en_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (go) begin
            state_r <= S_MOVE;
            fh_r    <= fh_nxt;
            bh_r    <= bh_nxt;
            fc_r    <= fc_nxt;
            bc_r    <= bc_nxt;
            mv_en_r <= mv_en_nxt;
          end
        end
        S_MOVE: begin
          state_r <= S_IDLE;
          mv_en_r <= 1'b0;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      mv_to_f_r <= mv_to_f_nxt;
      mv_addr_r <= mv_addr_nxt;
      sel_r     <= sel_nxt;
      empty_r   <= empty_nxt;
      drop_r    <= drop_nxt;
      occ_r     <= tot_ext[OCC_BITS-1:0];
    end
  end

  assign cmd_pop  = go;
  assign res_push = (state_r == S_MOVE);

  always_comb begin
    res_data              = '0;
    res_data.was_empty    = empty_r;
    res_data.push_dropped = drop_r;
    res_data.occupancy    = occ_r;
    case (sel_r)
      SRC_FRONT: res_data.pop_value = sext(f_rd_r);
      SRC_BACK:  res_data.pop_value = sext(b_rd_r);
      default:   res_data.pop_value = '0;
    endcase
  end

  assign stat.balanced = fc_eq || fc_gt;
  assign stat.over_cap = (tot > CAPACITY);

endmodule

// ===== src/front_middle_back_queue.sv =====
// Top level of the front/middle/back queue.
// A queue that pushes to and pops from its front, its middle (the last element of the front
// half) or its back. Each beat on the input side carries a mode and a value and yields exactly
// one result beat: the popped value, sign-extended from VALUE_BITS, an empty flag for a pop of
// an empty queue, a drop flag for a push into a full queue, and the element count afterwards
// (low 10 bits). Capacity is 2*HALF_DEPTH-1 elements, held in two single-write, single-read
// memories of HALF_DEPTH entries each. The executing unit handles each operation in an access
// state, for the access with the new value and the read of the element that crosses between the
// halves, then a move state, for writing that element into the other half; it takes no new beat
// until the move state is done. The result beat is pushed into the result queue from the move
// state and shows on the output once it is stored there. A two-entry command queue and a
// two-entry result queue let input and output stall independently of the unit.
// No clearing pass after reset.
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int HALF_DEPTH = 512,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_push,
  output logic                       in_full,
  input  logic [2:0]                 in_mode,
  input  logic signed [IN_BITS-1:0]  in_push_value,
  // result channel
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [OUT_BITS-1:0] out_pop_value,
  output logic                       out_was_empty,
  output logic                       out_push_dropped,
  output logic [OCC_BITS-1:0]        out_occupancy
);

  localparam int RES_BITS = $bits(res_t);

  logic                  cmd_empty, cmd_pop;
  op_t                   cmd_op;
  logic [VALUE_BITS-1:0] cmd_value;
  logic                  res_full, res_push;
  res_t                  res_data, res_q;
  logic [RES_BITS-1:0]   res_bits;
  stat_t                 stat;

  // decode and queue incoming beats
  fmbq_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_mode       (in_mode),
    .in_push_value (in_push_value),
    .cmd_empty     (cmd_empty),
    .cmd_op        (cmd_op),
    .cmd_value     (cmd_value),
    .cmd_pop       (cmd_pop)
  );

  // two halves plus rebalancing move
  fmbq_back #(
    .HALF_DEPTH (HALF_DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_op    (cmd_op),
    .cmd_value (cmd_value),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .stat      (stat)
  );

  // result beats wait here until popped
  fmbq_fifo #(
    .WIDTH (RES_BITS),
    .DEPTH (2)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .din   (res_data),
    .pop   (out_pop),
    .empty (out_empty),
    .dout  (res_bits)
  );

  assign res_q            = res_t'(res_bits);
  assign out_pop_value    = res_q.pop_value;
  assign out_was_empty    = res_q.was_empty;
  assign out_push_dropped = res_q.push_dropped;
  assign out_occupancy    = res_q.occupancy;

  // halves stay balanced and within capacity
  a_balance: assert property (@(posedge clk) disable iff (!rst_n)
    stat.balanced && !stat.over_cap)
    else $error("queue halves out of balance or over capacity");

  // every started command delivers its result in the following cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> res_push)
    else $error("command started without a result beat");

  // the unit only finishes into a result queue with room
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result beat pushed into a full result queue");

endmodule
